// File: src/mcg_pkg.sv
// Shared types, widths and calendar tables for the month calendar grid.
// Used by mcg_ctrl, mcg_datapath and month_calendar_grid; depends on nothing.
`default_nettype none
package mcg_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WD_W    = 3;

    // Range of accepted years
    localparam logic [YEAR_W-1:0] EPOCH_YEAR = 14'd1800;
    localparam logic [YEAR_W-1:0] MAX_YEAR   = 14'd9999;

    // Month codes
    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    localparam logic [WD_W-1:0] SUNDAY   = 3'd0;
    localparam logic [WD_W-1:0] SATURDAY = 3'd6;

    localparam logic [DAY_W-1:0] LEAP_FEB_LEN = 5'd29;

    // Day sum width; only its value mod 7 matters, peak is under 13k
    localparam int SUM_W  = 15;
    // Century count width: year / 100 of a 14-bit year
    localparam int CENT_W = 8;

    // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
    localparam int                PROD_W     = 27;
    localparam int                CENT_SHIFT = 19;
    localparam logic [PROD_W-1:0] CENT_RECIP = 27'd5243;
    localparam logic [YEAR_W-1:0] CENTURY    = 14'd100;

    // Days in a week, for the final mod 7 correction
    localparam logic [3:0] WEEK_LEN = 4'd7;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture a request word
        logic cent;        // capture year / 100
        logic year_info;   // capture leap flag, month length, centuries before
        logic calc_years;  // form the day sum of the whole years before
        logic calc_month;  // add the days of the months before, plus one
        logic emit_init;   // set day 1 and its weekday
        logic push_day;    // load a day word into the output register
        logic push_bad;    // load the invalid word into the output register
    } mcg_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic req_ok;      // latched year and month are in range
        logic last_day;    // current day is the final day of the month
        logic out_free;    // output register can take a word this cycle
    } mcg_status_t;

    // Days before the first of a month, common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of a month, common year
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                  n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
            default:               n = 5'd31;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// File: src/month_calendar_grid.sv
// Top level of the month calendar grid: controller plus datapath.
// Depends on mcg_pkg, mcg_ctrl and mcg_datapath.
//
//   channel | direction | ports
//   --------+-----------+------------------------------------------------------
//   s_      | in        | s_valid, s_ready, s_year[13:0], s_month[3:0]
//   m_      | out       | m_valid, m_ready, m_day_of_month[4:0], m_weekday[2:0],
//           |           | m_row_end, m_last, m_invalid
//
// A valid request puts its first day word in the output register after the range
// check, year / 100, leap and century terms, year days, month offset and weekday
// of the 1st, then one word per cycle while the output register is free (28 to 31
// words); an invalid one gives its single word. One request is in work at a time;
// the next is taken as soon as the last word sits in the output register. Reset
// (aresetn, synchronous, low) clears the controller and the output valid; a
// stalled m_ready holds the word and pauses emission.
`default_nettype none
module month_calendar_grid (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mcg_pkg::YEAR_W-1:0]  s_year,
    input  wire logic [mcg_pkg::MONTH_W-1:0] s_month,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mcg_pkg::DAY_W-1:0]        m_day_of_month,
    output logic [mcg_pkg::WD_W-1:0]         m_weekday,
    output logic                             m_row_end,
    output logic                             m_last,
    output logic                             m_invalid
);
    import mcg_pkg::*;

    mcg_cmd_t    cmd;
    mcg_status_t status;

    mcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mcg_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_year         (s_year),
        .s_month        (s_month),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_day_of_month (m_day_of_month),
        .m_weekday      (m_weekday),
        .m_row_end      (m_row_end),
        .m_last         (m_last),
        .m_invalid      (m_invalid)
    );

endmodule
`default_nettype wire

// File: src/mcg_datapath.sv
// Datapath of the month calendar grid: request registers, century split, day sum,
// mod 7 fold, day/weekday counters and the output register. Uses mcg_pkg.
`default_nettype none
module mcg_datapath (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mcg_pkg::mcg_cmd_t           cmd,
    output mcg_pkg::mcg_status_t             status,
    input  wire logic [mcg_pkg::YEAR_W-1:0]  s_year,
    input  wire logic [mcg_pkg::MONTH_W-1:0] s_month,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mcg_pkg::DAY_W-1:0]        m_day_of_month,
    output logic [mcg_pkg::WD_W-1:0]         m_weekday,
    output logic                             m_row_end,
    output logic                             m_last,
    output logic                             m_invalid
);
    import mcg_pkg::*;

    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [CENT_W-1:0]  cent_reg;
    logic [CENT_W-1:0]  prev_cent_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic               leap_reg;
    logic [DAY_W-1:0]   len_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [WD_W-1:0]    wd_reg;

    logic               out_valid_reg;
    logic [DAY_W-1:0]   out_day_reg;
    logic [WD_W-1:0]    out_wd_reg;
    logic               out_row_end_reg;
    logic               out_last_reg;
    logic               out_invalid_reg;

    // Century split and leap terms
    logic [PROD_W-1:0]  cent_prod;
    logic [YEAR_W-1:0]  hundreds;
    logic               cent_exact;
    logic               leap_now;

    // Day sum terms
    logic [SUM_W-1:0]   prev_year;
    logic [SUM_W-1:0]   year_days;
    logic [SUM_W-1:0]   month_days;

    // Mod 7 fold: 8 = 1 mod 7, so octal digits add up to the same residue
    logic [5:0]         fold_hi;
    logic [3:0]         fold_lo;
    logic [WD_W-1:0]    first_wd;
    logic [WD_W-1:0]    wd_inc;

    // year / 100 by reciprocal multiply; exact when 100 * quotient gives the year back
    assign cent_prod  = PROD_W'(year_reg) * CENT_RECIP;
    assign hundreds   = YEAR_W'(cent_reg) * CENTURY;
    assign cent_exact = (hundreds == year_reg);
    assign leap_now   = ((year_reg[1:0] == 2'b00) && !cent_exact)
                      || (cent_exact && (cent_reg[1:0] == 2'b00));

    // Weekday of 1st: (days since year 1 + 1) mod 7, with 365 = 1 mod 7
    assign prev_year  = SUM_W'(year_reg) - SUM_W'(1);
    assign year_days  = prev_year + (prev_year >> 2) - SUM_W'(prev_cent_reg)
                      + SUM_W'(prev_cent_reg >> 2);
    assign month_days = SUM_W'(days_before(month_reg))
                      + SUM_W'(leap_reg && (month_reg > FEBRUARY))
                      + SUM_W'(1);

    // Reduce the day sum mod 7
    assign fold_hi  = 6'(sum_reg[2:0]) + 6'(sum_reg[5:3]) + 6'(sum_reg[8:6])
                    + 6'(sum_reg[11:9]) + 6'(sum_reg[14:12]);
    assign fold_lo  = 4'(fold_hi[2:0]) + 4'(fold_hi[5:3]);
    assign first_wd = (fold_lo >= WEEK_LEN) ? WD_W'(fold_lo - WEEK_LEN)
                                            : fold_lo[WD_W-1:0];

    assign wd_inc = (wd_reg == SATURDAY) ? SUNDAY : wd_reg + WD_W'(1);

    // Request, day sum and counter registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            year_reg  <= s_year;
            month_reg <= s_month;
        end
        if (cmd.cent) begin
            cent_reg <= cent_prod[CENT_SHIFT +: CENT_W];
        end
        if (cmd.year_info) begin
            leap_reg      <= leap_now;
            prev_cent_reg <= cent_reg - CENT_W'(cent_exact);
            len_reg       <= (leap_now && (month_reg == FEBRUARY)) ? LEAP_FEB_LEN
                                                                   : month_len(month_reg);
        end
        if (cmd.calc_years) begin
            sum_reg <= year_days;
        end else if (cmd.calc_month) begin
            sum_reg <= sum_reg + month_days;
        end
        if (cmd.emit_init) begin
            day_reg <= DAY_W'(1);
            wd_reg  <= first_wd;
        end else if (cmd.push_day) begin
            day_reg <= day_reg + DAY_W'(1);
            wd_reg  <= wd_inc;
        end
    end

    // Output register: hold a word until taken, refill in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.push_day || cmd.push_bad) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push_day) begin
            out_day_reg     <= day_reg;
            out_wd_reg      <= wd_reg;
            out_row_end_reg <= (wd_reg == SATURDAY);
            out_last_reg    <= status.last_day;
            out_invalid_reg <= 1'b0;
        end else if (cmd.push_bad) begin
            out_day_reg     <= '0;
            out_wd_reg      <= SUNDAY;
            out_row_end_reg <= 1'b0;
            out_last_reg    <= 1'b1;
            out_invalid_reg <= 1'b1;
        end
    end

    // Status back to the controller
    always_comb begin
        status.req_ok   = (month_reg >= JANUARY) && (month_reg <= DECEMBER)
                        && (year_reg >= EPOCH_YEAR) && (year_reg <= MAX_YEAR);
        status.last_day = (day_reg == len_reg);
        status.out_free = !out_valid_reg || m_ready;
    end

    assign m_valid        = out_valid_reg;
    assign m_day_of_month = out_day_reg;
    assign m_weekday      = out_wd_reg;
    assign m_row_end      = out_row_end_reg;
    assign m_last         = out_last_reg;
    assign m_invalid      = out_invalid_reg;

endmodule
`default_nettype wire

// File: src/mcg_ctrl.sv
// Controller of the month calendar grid: sequences capture, the century split,
// the day sum and the emission of day words or of the invalid word. Uses mcg_pkg.
`default_nettype none
module mcg_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire mcg_pkg::mcg_status_t status,
    output mcg_pkg::mcg_cmd_t         cmd
);
    import mcg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CENT,
        ST_CALC,
        ST_MONTH,
        ST_INIT,
        ST_EMIT,
        ST_BAD
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.req_ok ? ST_CENT : ST_BAD;
            end
            ST_CENT: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_MONTH;
            end
            ST_MONTH: begin
                state_next = ST_INIT;
            end
            ST_INIT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free && status.last_day) state_next = ST_IDLE;
            end
            ST_BAD: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands
    always_comb begin
        cmd            = '0;
        cmd.load       = (state_reg == ST_IDLE) && s_valid;
        cmd.cent       = (state_reg == ST_CHECK);
        cmd.year_info  = (state_reg == ST_CENT);
        cmd.calc_years = (state_reg == ST_CALC);
        cmd.calc_month = (state_reg == ST_MONTH);
        cmd.emit_init  = (state_reg == ST_INIT);
        cmd.push_day   = (state_reg == ST_EMIT) && status.out_free;
        cmd.push_bad   = (state_reg == ST_BAD) && status.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

// File: tb/mcg_checker.sv
`timescale 1ns / 1ps
// Scoreboard for month_calendar_grid: predicts the day words of each request and
// checks every word taken from the m_ channel. Depends on mcg_pkg only.
module mcg_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [mcg_pkg::YEAR_W-1:0]  s_year,
    input  logic [mcg_pkg::MONTH_W-1:0] s_month,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic [mcg_pkg::DAY_W-1:0]   m_day_of_month,
    input  logic [mcg_pkg::WD_W-1:0]    m_weekday,
    input  logic                        m_row_end,
    input  logic                        m_last,
    input  logic                        m_invalid,
    output int                          mismatches,
    output int                          words_due
);
    import mcg_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0] day;
        logic [WD_W-1:0]  wday;
        logic             row_end;
        logic             last;
        logic             invalid;
    } day_word_t;

    // day words still owed by the block, oldest first
    day_word_t due_q[$];

    function automatic bit leap_year(input int yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    function automatic int month_days(input int yr, input int mo);
        if (mo == FEBRUARY) return leap_year(yr) ? 29 : 28;
        if (mo == 4 || mo == 6 || mo == 9 || mo == 11) return 30;
        return 31;
    endfunction

    // Queue the words one request should produce
    function automatic void forecast_month(input int yr, input int mo);
        day_word_t w;
        int span;
        int first_wd;
        int wd;
        int k;
        int d;
        int len;
        if (mo < JANUARY || mo > DECEMBER || yr < EPOCH_YEAR || yr > MAX_YEAR) begin
            w.day     = '0;
            w.wday    = SUNDAY;
            w.row_end = 1'b0;
            w.last    = 1'b1;
            w.invalid = 1'b1;
            due_q.push_back(w);
            return;
        end
        // whole days since 1 January of year 1, a Monday
        span = 365 * (yr - 1) + (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400;
        for (k = JANUARY; k < mo; k++) begin
            span += month_days(yr, k);
        end
        first_wd = (span + 1) % 7;
        len = month_days(yr, mo);
        for (d = 1; d <= len; d++) begin
            wd        = (first_wd + d - 1) % 7;
            w.day     = d[DAY_W-1:0];
            w.wday    = wd[WD_W-1:0];
            w.row_end = (wd == SATURDAY);
            w.last    = (d == len);
            w.invalid = 1'b0;
            due_q.push_back(w);
        end
    endfunction

    // Count a mismatch and log it
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("%0t: calendar word mismatch: %s", $time, what);
    endtask

    task automatic check_word();
        day_word_t want;
        if (due_q.size() == 0) begin
            note_mismatch("word arrived with none due");
            return;
        end
        want = due_q.pop_front();
        if (m_day_of_month !== want.day)
            note_mismatch($sformatf("day_of_month %0d, want %0d", m_day_of_month, want.day));
        if (m_weekday !== want.wday)
            note_mismatch($sformatf("weekday %0d, want %0d (day %0d)",
                                    m_weekday, want.wday, want.day));
        if (m_row_end !== want.row_end)
            note_mismatch($sformatf("row_end %b, want %b (day %0d)",
                                    m_row_end, want.row_end, want.day));
        if (m_last !== want.last)
            note_mismatch($sformatf("last %b, want %b (day %0d)", m_last, want.last, want.day));
        if (m_invalid !== want.invalid)
            note_mismatch($sformatf("invalid %b, want %b", m_invalid, want.invalid));
    endtask

    // Check words leaving, then predict for the request entering
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_word();
            if (s_valid && s_ready) forecast_month(s_year, s_month);
            words_due = due_q.size();
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Top of the month_calendar_grid testbench: clock, reset, request and sink drivers,
// verdict. Depends on mcg_pkg, month_calendar_grid and mcg_checker.
module tb;
    import mcg_pkg::*;

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [YEAR_W-1:0]    s_year  = '0;
    logic [MONTH_W-1:0]   s_month = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [DAY_W-1:0]     m_day_of_month;
    logic [WD_W-1:0]      m_weekday;
    logic                 m_row_end;
    logic                 m_last;
    logic                 m_invalid;
    int                   mismatches;
    int                   words_due;
    bit                   steady = 1'b0;

    month_calendar_grid DUT (.*);

    mcg_checker checker_i (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Offer one request word after a random gap (none when steady); return at the
    // falling edge after it is taken, with valid still high
    task automatic send_request(input logic [YEAR_W-1:0] yr, input logic [MONTH_W-1:0] mo);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_year  = yr;
        s_month = mo;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Request stimulus and verdict
    initial begin : stimulus
        int dir_year [24];
        int dir_month [24];
        int n;
        int pick;
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;

        dir_year  = '{1800, 1799, 9999, 10000, 16383, 0, 2000, 1900,
                      2024, 2023, 2000, 1800, 2024, 2024, 2024, 2024,
                      2021, 2021, 2021, 2021, 2023, 2023, 2023, 2023};
        dir_month = '{JANUARY, JANUARY, DECEMBER, JANUARY, 15, 0,
                      FEBRUARY, FEBRUARY, FEBRUARY, FEBRUARY, 3, FEBRUARY,
                      0, 13, 14, 15, 4, 6, 9, 11, 5, 7, 8, 10};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: range edges, leap rules, every month length, bad months
        for (n = 0; n < 24; n++) begin
            send_request(YEAR_W'(dir_year[n]), MONTH_W'(dir_month[n]));
        end

        // Random: mostly valid months, some century Februaries, some noise
        for (n = 0; n < 76; n++) begin
            if (n % 25 == 0) steady = ($urandom_range(0, 2) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                yr = YEAR_W'($urandom_range(EPOCH_YEAR, MAX_YEAR));
                mo = MONTH_W'($urandom_range(JANUARY, DECEMBER));
            end else if (pick < 85) begin
                yr = YEAR_W'(100 * $urandom_range(18, 99));
                mo = (pick < 80) ? FEBRUARY : MONTH_W'($urandom_range(JANUARY, DECEMBER));
            end else begin
                yr = YEAR_W'($urandom_range(0, 16383));
                mo = MONTH_W'($urandom_range(0, 15));
            end
            send_request(yr, mo);
        end
        s_valid = 1'b0;

        // Drain, then allow a little extra time for stray words
        while (words_due != 0) @(negedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result sink: random stalls, quiet stretches, one long hold-off mid run
    initial begin : sink
        int stall;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (taken == 1200) begin
                stall = 400;
            end else begin
                stall = quiet ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    // Hang guard
    initial begin : watchdog
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
